// ===== rtl/mapg_pkg.sv =====
// Package: constants, register indexes and the duty mapping for the motor arming PWM gate.
`default_nettype none

package mapg_pkg;

	localparam int NumMotors = 4;
	localparam int WidthW    = 16;
	localparam int DutyW     = 13;
	localparam int AuxW      = 16;

	localparam logic [WidthW-1:0] ScaleBase = 16'd1100;
	localparam logic [DutyW-1:0]  DutyMax   = 13'd4096;
	localparam logic [DutyW-1:0]  DeadZone  = 13'd100;

	localparam logic [WidthW-1:0] LowWidthRst       = 16'd1100;
	localparam logic [WidthW-1:0] MiddleWidthRst    = 16'd1500;
	localparam logic [WidthW-1:0] StartupPacketsRst = 16'd100;
	localparam logic [WidthW-1:0] CountMax          = 16'hFFFF;

	localparam int InDataW  = 96;
	localparam int InUserW  = 3;
	localparam int OutDataW = 88;
	localparam int OutUserW = 1;

	typedef enum logic [1:0] {
		REG_LOW_WIDTH       = 2'd0,
		REG_MIDDLE_WIDTH    = 2'd1,
		REG_STARTUP_PACKETS = 2'd2
	} reg_index_t;

	typedef logic [DutyW-1:0] duty_t;

	// Map a pulse width to a duty: (w - 1100) * 41 >> 3, clamp, dead zone.
	function automatic duty_t to_duty(input logic [WidthW-1:0] w);
		logic [WidthW-1:0] diff;
		logic [21:0]       prod;
		logic [18:0]       scaled;
		duty_t             res;
		diff   = w - ScaleBase;
		prod   = {1'b0, diff, 5'b0} + {3'b0, diff, 3'b0} + {6'b0, diff};
		scaled = prod[21:3];
		if (w < ScaleBase) begin
			res = '0;
		end else if (scaled > {6'b0, DutyMax}) begin
			res = DutyMax;
		end else if (scaled < {6'b0, DeadZone}) begin
			res = '0;
		end else begin
			res = scaled[DutyW-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/motor_arming_pwm_gate_unit.sv =====
// Motor arming PWM gate: arming control, startup check and duty mapping per command packet.
// Stages: each item passes the input stage and then the result stage, both registered.
// Throughput: one transaction per cycle; the input stage advances whenever the result register
// is empty or being taken, so the arming and count state is updated once per item in order.
// Reset: disarmed, packet count zero, outputs shut down (duties and aux words zero, stopped set),
// registers at 1100 / 1500 / 100, both stages empty.
`default_nettype none

module motor_arming_pwm_gate_unit
	import mapg_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [WidthW-1:0]   cfg_data,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	// width_a, width_b, width_c, width_d, aux_first, aux_second
	input  wire logic [InDataW-1:0]  s_axis_tdata,
	// packet_valid, config_mode, failsafe
	input  wire logic [InUserW-1:0]  s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// duty_zero, duty_one, duty_two, duty_three, aux_out_first, aux_out_second,
	// motors_stopped, armed, two zero bits
	output logic [OutDataW-1:0]      m_axis_tdata,
	// buffer_written
	output logic [OutUserW-1:0]      m_axis_tuser
);

	logic [WidthW-1:0] low_width_q;
	logic [WidthW-1:0] middle_width_q;
	logic [WidthW-1:0] startup_packets_q;

	logic                 valid_s1;
	logic [InDataW-1:0]   data_s1;
	logic [InUserW-1:0]   user_s1;

	logic                 armed_q;
	logic [WidthW-1:0]    count_q;
	logic                 stopped_q;
	duty_t                duty_q [NumMotors];
	logic [AuxW-1:0]      aux_q [2];

	logic                 out_valid_q;
	logic [OutDataW-1:0]  out_data_q;
	logic                 out_written_q;

	logic                 advance;
	logic [WidthW-1:0]    w [NumMotors];
	logic                 pkt_ok;
	logic                 fs;
	logic                 armed_d;
	logic [WidthW-1:0]    count_d;
	logic                 stopped_d;
	duty_t                duty_d [NumMotors];
	logic [AuxW-1:0]      aux_d [2];
	logic                 written_d;
	logic                 armed_mid;
	logic                 any_high;
	logic                 all_low;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_width_q       <= LowWidthRst;
			middle_width_q    <= MiddleWidthRst;
			startup_packets_q <= StartupPacketsRst;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_WIDTH:       low_width_q       <= cfg_data;
				REG_MIDDLE_WIDTH:    middle_width_q    <= cfg_data;
				REG_STARTUP_PACKETS: startup_packets_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			user_s1 <= s_axis_tuser;
		end
	end

	always_comb begin
		for (int i = 0; i < NumMotors; i++) begin
			w[i] = data_s1[i*WidthW +: WidthW];
		end
		pkt_ok    = user_s1[0] && !user_s1[1];
		fs        = user_s1[2];
		armed_d   = armed_q;
		count_d   = count_q;
		stopped_d = stopped_q;
		duty_d    = duty_q;
		aux_d     = aux_q;
		written_d = 1'b0;
		any_high  = 1'b0;
		all_low   = 1'b1;
		for (int i = 0; i < NumMotors; i++) begin
			if (w[i] > middle_width_q) begin
				any_high = 1'b1;
			end
			if (w[i] > low_width_q) begin
				all_low = 1'b0;
			end
		end
		armed_mid = armed_q;
		if (pkt_ok) begin
			if (!armed_q) begin
				if (count_q == '0) begin
					armed_mid = 1'b1;
				end else begin
					for (int i = 0; i < NumMotors; i++) begin
						duty_d[i] = '0;
					end
					aux_d[0]  = '0;
					aux_d[1]  = '0;
					stopped_d = 1'b1;
					written_d = 1'b1;
				end
			end
			if (count_q != CountMax) begin
				count_d = count_q + 16'd1;
			end
			armed_d = armed_mid;
			if (!fs && armed_mid) begin
				if (count_d < startup_packets_q && any_high) begin
					armed_d = 1'b0;
				end else begin
					duty_d[0] = to_duty(w[3]);
					duty_d[1] = to_duty(w[0]);
					duty_d[2] = to_duty(w[1]);
					duty_d[3] = to_duty(w[2]);
					aux_d[0]  = data_s1[4*WidthW +: AuxW];
					aux_d[1]  = data_s1[4*WidthW+AuxW +: AuxW];
					stopped_d = all_low;
					written_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			count_q   <= '0;
			stopped_q <= 1'b1;
			for (int i = 0; i < NumMotors; i++) begin
				duty_q[i] <= '0;
			end
			aux_q[0]  <= '0;
			aux_q[1]  <= '0;
		end else if (advance) begin
			armed_q   <= armed_d;
			count_q   <= count_d;
			stopped_q <= stopped_d;
			duty_q    <= duty_d;
			aux_q     <= aux_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q    <= {2'b00, armed_d, stopped_d, aux_d[1], aux_d[0],
				duty_d[3], duty_d[2], duty_d[1], duty_d[0]};
			out_written_q <= written_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_written_q;

	ap_arm_only_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(armed_q) |-> $past(count_q) == '0)
		else $error("arming after the first packet");

	ap_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + 16'd1)
		else $error("packet count moved by other than one");

	ap_duty_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		duty_q[0] <= DutyMax && duty_q[1] <= DutyMax &&
		duty_q[2] <= DutyMax && duty_q[3] <= DutyMax)
		else $error("duty above full scale");

	ap_shutdown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && written_d && !armed_d |=>
			duty_q[0] == '0 && duty_q[1] == '0 && duty_q[2] == '0 && duty_q[3] == '0 &&
			aux_q[0] == '0 && aux_q[1] == '0 && stopped_q)
		else $error("shutdown left output buffer nonzero");

endmodule

`default_nettype wire
